[hw/rtl/hcc_pkg.sv]
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types, constants and helper functions for the Hall commutation block.
// ----------------------------------------------------------------------------
package hcc_pkg;

    localparam int TABLE_W   = 18;
    localparam int DUTY_W    = 16;
    localparam int MAG_W     = 15;
    localparam int POS_W     = 32;
    localparam int HALL_W    = 3;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = TABLE_W;

    localparam logic [TABLE_W-1:0] FWD_TABLE_RST = 18'd171234;
    localparam logic [TABLE_W-1:0] REV_TABLE_RST = 18'd83853;
    localparam logic [DUTY_W-1:0]  DRIVE_DUTY_RST = 16'd2000;
    localparam logic [MAG_W-1:0]   MAX_DUTY_RST  = 15'd32767;

    // invalid codes tolerated in a row before the fault latches
    localparam logic [2:0] ERR_LIMIT = 3'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_TABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_TABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_DUTY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY   = 2'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_HALL    = 2'd0,
        ACT_ENABLE  = 2'd1,
        ACT_DISABLE = 2'd2
    } action_t;

    typedef struct packed {
        logic [TABLE_W-1:0] fwd_table;
        logic [TABLE_W-1:0] rev_table;
        logic [DUTY_W-1:0]  drive_duty;
        logic [MAG_W-1:0]   max_duty;
    } cfg_t;

    typedef struct packed {
        logic              running;
        logic              hall_fault;
        logic [POS_W-1:0]  position;
        logic [MAG_W-1:0]  pwm_c;
        logic [MAG_W-1:0]  pwm_b;
        logic [MAG_W-1:0]  pwm_a;
        logic [2:0]        gate_en;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // three-bit table entry for Hall code 1..6
    function automatic logic [2:0] table_entry(input logic [TABLE_W-1:0] tbl,
                                               input logic [HALL_W-1:0] code);
        logic [2:0] e;
        unique case (code)
            3'd1:    e = tbl[2:0];
            3'd2:    e = tbl[5:3];
            3'd3:    e = tbl[8:6];
            3'd4:    e = tbl[11:9];
            3'd5:    e = tbl[14:12];
            3'd6:    e = tbl[17:15];
            default: e = 3'd0;
        endcase
        return e;
    endfunction

    // (v + 1) mod 6 for a three-bit v
    function automatic logic [2:0] inc_mod6(input logic [2:0] v);
        logic [2:0] r;
        unique case (v)
            3'd5:    r = 3'd0;
            3'd6:    r = 3'd1;
            3'd7:    r = 3'd2;
            default: r = v + 3'd1;
        endcase
        return r;
    endfunction

    // entry mod 6
    function automatic logic [2:0] step_of(input logic [2:0] e);
        logic [2:0] r;
        unique case (e)
            3'd6:    r = 3'd0;
            3'd7:    r = 3'd1;
            default: r = e;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] gates_of(input logic [2:0] step);
        logic [2:0] g;
        unique case (step)
            3'd0, 3'd3: g = 3'b011;
            3'd1, 3'd4: g = 3'b101;
            default:    g = 3'b110;
        endcase
        return g;
    endfunction

endpackage

[hw/rtl/hcc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// hcc_cfg_regs
// Configuration register file, write-only, reset to the default tables.
// ----------------------------------------------------------------------------
module hcc_cfg_regs
    import hcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FWD_TABLE:  cfg_next.fwd_table  = cfg_wr_data;
                CFG_REV_TABLE:  cfg_next.rev_table  = cfg_wr_data;
                CFG_DRIVE_DUTY: cfg_next.drive_duty = cfg_wr_data[DUTY_W-1:0];
                default:        cfg_next.max_duty   = cfg_wr_data[MAG_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fwd_table  <= FWD_TABLE_RST;
            cfg_reg.rev_table  <= REV_TABLE_RST;
            cfg_reg.drive_duty <= DRIVE_DUTY_RST;
            cfg_reg.max_duty   <= MAX_DUTY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/hcc_core.sv]
// ----------------------------------------------------------------------------
// hcc_core
// Controller state and the one-pass update for a single request.
// ----------------------------------------------------------------------------
module hcc_core
    import hcc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                fire,
    input  logic [ACTION_W-1:0] action,
    input  logic [HALL_W-1:0]   hall,
    output result_t             result_next
);

    logic              enabled_reg,  enabled_next;
    logic [2:0]        last_sector_reg, last_sector_next;
    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic [2:0]        err_reg,      err_next;
    logic [HALL_W-1:0] cur_hall_reg, cur_hall_next;
    logic              fault_reg,    fault_next;
    logic [2:0]        gate_reg,     gate_next;
    logic [MAG_W-1:0]  duty_a_reg, duty_b_reg, duty_c_reg;
    logic [MAG_W-1:0]  duty_a_next, duty_b_next, duty_c_next;

    logic              hall_ok;
    logic              neg;
    logic [MAG_W+1:0]  mag_raw;
    logic [MAG_W-1:0]  mag_clamped;
    logic [2:0]        sector;
    logic [2:0]        err_inc;
    logic [2:0]        step;
    logic [MAG_W-1:0]  comm_mag;
    logic              comm_rev;
    logic              do_comm;

    assign hall_ok = (hall != 3'd0) && (hall != 3'd7);
    assign neg     = cfg.drive_duty[DUTY_W-1];
    // -32768 comes out as 32768 thanks to the extra bit
    assign mag_raw = neg ? ({1'b0, ~cfg.drive_duty} + 17'd1) : {1'b0, cfg.drive_duty};
    assign mag_clamped = (mag_raw > {2'b00, cfg.max_duty}) ? cfg.max_duty
                                                          : mag_raw[MAG_W-1:0];
    assign sector  = table_entry(cfg.fwd_table, hall) - 3'd1;
    assign err_inc = err_reg + 3'd1;

    always_comb begin
        enabled_next     = enabled_reg;
        last_sector_next = last_sector_reg;
        pos_next         = pos_reg;
        err_next         = err_reg;
        cur_hall_next    = cur_hall_reg;
        fault_next       = fault_reg;
        gate_next        = gate_reg;
        duty_a_next      = duty_a_reg;
        duty_b_next      = duty_b_reg;
        duty_c_next      = duty_c_reg;
        do_comm          = 1'b0;
        comm_mag         = '0;
        comm_rev         = 1'b0;

        unique case (action)
            ACT_HALL: begin
                cur_hall_next = hall;
                if (!hall_ok) begin
                    err_next = err_inc;
                    if (err_inc > ERR_LIMIT) begin
                        fault_next   = 1'b1;
                        gate_next    = 3'b000;
                        enabled_next = 1'b0;
                        err_next     = 3'd0;
                    end
                end else begin
                    err_next = 3'd0;
                    if (sector == inc_mod6(last_sector_reg)) begin
                        pos_next = pos_reg + 32'd1;
                    end else if (last_sector_reg == inc_mod6(sector)) begin
                        pos_next = pos_reg - 32'd1;
                    end
                    last_sector_next = sector;
                    do_comm  = enabled_reg;
                    comm_mag = mag_clamped;
                    comm_rev = neg;
                end
            end
            ACT_ENABLE: begin
                if (!fault_reg) begin
                    enabled_next = 1'b1;
                    do_comm      = 1'b1;
                end
            end
            ACT_DISABLE: begin
                gate_next    = 3'b000;
                enabled_next = 1'b0;
            end
            default: ;
        endcase

        // commutation uses the Hall code held after this request
        step = step_of(table_entry(comm_rev ? cfg.rev_table : cfg.fwd_table,
                                   cur_hall_next));
        if (do_comm) begin
            if ((cur_hall_next == 3'd0) || (cur_hall_next == 3'd7)) begin
                gate_next = 3'b000;
            end else begin
                gate_next   = gates_of(step);
                duty_a_next = (step[2:1] == 2'd0) ? comm_mag : '0;
                duty_b_next = (step[2:1] == 2'd1) ? comm_mag : '0;
                duty_c_next = (step[2:1] == 2'd2) ? comm_mag : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg     <= 1'b0;
            last_sector_reg <= 3'd0;
            pos_reg         <= '0;
            err_reg         <= 3'd0;
            cur_hall_reg    <= '0;
            fault_reg       <= 1'b0;
            gate_reg        <= 3'b000;
            duty_a_reg      <= '0;
            duty_b_reg      <= '0;
            duty_c_reg      <= '0;
        end else if (fire) begin
            enabled_reg     <= enabled_next;
            last_sector_reg <= last_sector_next;
            pos_reg         <= pos_next;
            err_reg         <= err_next;
            cur_hall_reg    <= cur_hall_next;
            fault_reg       <= fault_next;
            gate_reg        <= gate_next;
            duty_a_reg      <= duty_a_next;
            duty_b_reg      <= duty_b_next;
            duty_c_reg      <= duty_c_next;
        end
    end

    always_comb begin
        result_next.gate_en    = gate_next;
        result_next.pwm_a      = duty_a_next;
        result_next.pwm_b      = duty_b_next;
        result_next.pwm_c      = duty_c_next;
        result_next.position   = pos_next;
        result_next.hall_fault = fault_next;
        result_next.running    = enabled_next;
    end

endmodule

[hw/rtl/hall_commutation_controller.sv]
// ----------------------------------------------------------------------------
// hall_commutation_controller
// Six-step BLDC commutation driven by Hall events, enable and disable requests.
// ----------------------------------------------------------------------------
// Each request on the s_ channel (tuser = action, tdata = Hall code) yields
// exactly one result on the m_ channel showing gate enables, the three phase
// PWM values, the signed position count and the fault/running flags after
// the request. Throughput is one request per clock unless m_ stalls: the
// request sits in an input register, one pass of shallow logic updates the
// controller state and loads the result register, which drives m_tvalid.
// The input register keeps taking requests while a result waits on a
// stalled m_ side, until it holds one itself. A Hall fault (four invalid
// codes in a row) latches until reset and blocks enable. Configuration
// (sector tables, signed drive duty, duty clamp) is written through cfg_*
// while the block is idle: a rule for the user, not enforced by the block. No read-back.
// ----------------------------------------------------------------------------
module hall_commutation_controller
    import hcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration writes: 0 fwd_table, 1 rev_table, 2 drive_duty, 3 max_duty
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [2:0] hall
    input  logic [1:0]            s_tuser,   // [1:0] action

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] gate_en, [17:3] pwm_a, [32:18] pwm_b, [47:33] pwm_c,
    // [79:48] position, [80] hall_fault, [81] running, [87:82] zero
    output logic [87:0]           m_tdata
);

    cfg_t    cfg;
    result_t result_next;

    // input register
    logic                in_valid_reg, in_valid_next;
    logic [ACTION_W-1:0] in_action_reg;
    logic [HALL_W-1:0]   in_hall_reg;

    // result register
    logic                out_valid_reg, out_valid_next;
    result_t             out_data_reg;

    logic fire;

    // a request is processed when the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser;
            in_hall_reg   <= s_tdata[HALL_W-1:0];
        end
        if (fire) begin
            out_data_reg <= result_next;
        end
    end

    hcc_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    hcc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .fire        (fire),
        .action      (in_action_reg),
        .hall        (in_hall_reg),
        .result_next (result_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(88 - RESULT_W){1'b0}}, out_data_reg};

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Hall commutation controller.
// ----------------------------------------------------------------------------
// A scripted opening walks the drive through unknown actions, invalid codes,
// enable with no valid Hall code, one turn forward, two back and disable. After
// that, phases of random requests run under several table, duty and clamp
// settings. Most requests follow the rotation so that the position keeps
// moving. Near the end four invalid codes latch the Hall fault, since only
// reset clears it. Each request is predicted as it is accepted. Every report
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import hcc_pkg::*;

    // action code outside the enum; the block must ignore it
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 140;
    localparam int TAIL_ITEMS  = 20;
    localparam int CYCLE_LIMIT = 400000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [2:0] hall
    logic [1:0]            s_tuser;   // [1:0] action
    logic                  m_tvalid;
    logic                  m_tready;
    // [2:0] gate_en, [17:3] pwm_a, [32:18] pwm_b, [47:33] pwm_c,
    // [79:48] position, [80] hall_fault, [81] running, [87:82] zero
    logic [87:0]           m_tdata;

    hall_commutation_controller dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Opening script. Reports are typed in only where they are obvious:
    // straight after reset, enable with no valid code, and the first step.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [HALL_W-1:0]   hall;
        logic                typed;
        result_t             want;
    } script_row_t;

    localparam result_t CLEAR_REPORT = '0;
    localparam result_t ARMED_REPORT = '{running: 1'b1, default: '0};
    // code 5 -> entry 1 -> step 1: gates A,C, PWM on A at the reset duty
    localparam result_t FIRST_STEP   = '{1'b1, 1'b0, 32'd0, 15'd0, 15'd0, 15'd2000, 3'b101};
    localparam result_t NONE         = '0;

    localparam int SCRIPT_LEN = 23;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{ACT_UNKNOWN, 3'd0, 1'b1, CLEAR_REPORT},  // ignored right after reset
        '{ACT_HALL,    3'd0, 1'b1, CLEAR_REPORT},  // invalid code, drive off
        '{ACT_HALL,    3'd7, 1'b1, CLEAR_REPORT},  // second invalid code
        '{ACT_ENABLE,  3'd5, 1'b1, ARMED_REPORT},  // runs, but gates stay off
        '{ACT_HALL,    3'd5, 1'b1, FIRST_STEP},    // sector 0, no position move
        '{ACT_HALL,    3'd1, 1'b0, NONE},          // forward sweep, sectors 1..5
        '{ACT_HALL,    3'd3, 1'b0, NONE},
        '{ACT_HALL,    3'd2, 1'b0, NONE},
        '{ACT_HALL,    3'd6, 1'b0, NONE},
        '{ACT_HALL,    3'd4, 1'b0, NONE},
        '{ACT_HALL,    3'd5, 1'b0, NONE},          // wraps 5 -> 0
        '{ACT_HALL,    3'd4, 1'b0, NONE},          // backward 0 -> 5
        '{ACT_HALL,    3'd6, 1'b0, NONE},
        '{ACT_HALL,    3'd0, 1'b0, NONE},          // three invalid, no fault yet
        '{ACT_HALL,    3'd7, 1'b0, NONE},
        '{ACT_HALL,    3'd0, 1'b0, NONE},
        '{ACT_HALL,    3'd6, 1'b0, NONE},          // same sector, count cleared
        '{ACT_DISABLE, 3'd3, 1'b0, NONE},          // gates off, PWM kept
        '{ACT_HALL,    3'd2, 1'b0, NONE},          // tracked while disabled
        '{ACT_ENABLE,  3'd0, 1'b0, NONE},          // enable at zero duty
        '{ACT_UNKNOWN, 3'd7, 1'b0, NONE},
        '{ACT_DISABLE, 3'd0, 1'b0, NONE},
        '{ACT_DISABLE, 3'd6, 1'b0, NONE}           // disable while disabled
    };

    // ------------------------------------------------------------------------
    // Controller model state and its copy of the registers
    // ------------------------------------------------------------------------
    logic [TABLE_W-1:0] ctl_fwd;
    logic [TABLE_W-1:0] ctl_rev;
    logic [DUTY_W-1:0]  ctl_duty;
    logic [MAG_W-1:0]   ctl_max;
    logic               ctl_enabled;
    logic               ctl_fault;
    logic [2:0]         ctl_sector;
    logic [2:0]         ctl_errs;
    logic [HALL_W-1:0]  ctl_hall;
    logic [2:0]         ctl_gates;
    logic [POS_W-1:0]   ctl_pos;
    logic [MAG_W-1:0]   ctl_pwm [3];

    result_t status_queue [$];     // predicted reports, oldest first
    int      mismatch_count  = 0;
    int      reports_checked = 0;
    int      requests_sent   = 0;
    int      settings_loaded = 0;
    int      cycle_count     = 0;
    bit      send_burst      = 0;  // sender runs with no gaps
    bit      take_burst      = 0;  // receiver runs with no stalls
    bit      spin_up         = 1;  // direction of the simulated rotor

    function automatic logic [2:0] sector_entry(input logic [TABLE_W-1:0] tbl,
                                                input logic [HALL_W-1:0] code);
        int k;
        k = code;
        return tbl[3*(k-1) +: 3];
    endfunction

    // drive gates and PWM for the current Hall code
    function automatic void drive_phases(input logic [15:0] mag, input bit rev);
        int st;
        logic [15:0] m;
        if (!ctl_enabled)
            return;
        if (ctl_hall < 1 || ctl_hall > 6) begin
            ctl_gates = 3'b000;
            return;
        end
        st = sector_entry(rev ? ctl_rev : ctl_fwd, ctl_hall) % 6;
        m = (mag > {1'b0, ctl_max}) ? {1'b0, ctl_max} : mag;
        // steps 0/3 drive A,B; 1/4 drive A,C; 2/5 drive B,C
        ctl_gates = (st % 3 == 0) ? 3'b011 : (st % 3 == 1) ? 3'b101 : 3'b110;
        ctl_pwm = '{default: '0};
        ctl_pwm[st/2] = m[14:0];
    endfunction

    function automatic result_t step_controller(input logic [ACTION_W-1:0] act,
                                                input logic [HALL_W-1:0] hall);
        int sec;
        int last;
        logic [15:0] mag;
        bit neg;
        result_t r;
        case (act)
            ACT_HALL: begin
                ctl_hall = hall;
                if (hall == 0 || hall == 7) begin
                    ctl_errs = ctl_errs + 3'd1;
                    if (ctl_errs > ERR_LIMIT) begin
                        ctl_fault   = 1'b1;
                        ctl_gates   = 3'b000;
                        ctl_enabled = 1'b0;
                        ctl_errs    = '0;
                    end
                end else begin
                    sec  = (sector_entry(ctl_fwd, hall) - 1) & 7;
                    last = ctl_sector;
                    neg  = ctl_duty[15];
                    // -32768 keeps its bit pattern, i.e. magnitude 32768
                    mag  = neg ? -ctl_duty : ctl_duty;
                    ctl_errs = '0;
                    if (sec == (last + 1) % 6)
                        ctl_pos = ctl_pos + 1;
                    if (last == (sec + 1) % 6)
                        ctl_pos = ctl_pos - 1;
                    ctl_sector = sec[2:0];
                    drive_phases(mag, neg);
                end
            end
            ACT_ENABLE: begin
                if (!ctl_fault) begin
                    ctl_enabled = 1'b1;
                    drive_phases(16'd0, 1'b0);
                end
            end
            ACT_DISABLE: begin
                ctl_gates   = 3'b000;
                ctl_enabled = 1'b0;
            end
            default: ;
        endcase
        r.gate_en    = ctl_gates;
        r.pwm_a      = ctl_pwm[0];
        r.pwm_b      = ctl_pwm[1];
        r.pwm_c      = ctl_pwm[2];
        r.position   = ctl_pos;
        r.hall_fault = ctl_fault;
        r.running    = ctl_enabled;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side. Tasks start and end at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send(input logic [ACTION_W-1:0] act, input logic [HALL_W-1:0] hall,
                        input logic typed, input result_t want);
        int gap;
        result_t predicted;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, hall};
        do @(posedge aclk); while (!s_tready);
        predicted = step_controller(act, hall);
        status_queue.push_back(typed ? want : predicted);
        requests_sent++;
        @(negedge aclk);
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
    endtask

    // hold off until every report is back; every request gives one report,
    // the extra cycles just cover the pipeline
    task automatic drain;
        s_tvalid <= 1'b0;
        while (status_queue.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_setting(input logic [TABLE_W-1:0] fwd, input logic [TABLE_W-1:0] rev,
                                input logic [DUTY_W-1:0] duty, input logic [MAG_W-1:0] maxd);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_FWD_TABLE;
        cfg_wr_data <= fwd;
        @(negedge aclk);
        cfg_index   <= CFG_REV_TABLE;
        cfg_wr_data <= rev;
        @(negedge aclk);
        cfg_index   <= CFG_DRIVE_DUTY;
        cfg_wr_data <= {2'b0, duty};
        @(negedge aclk);
        cfg_index   <= CFG_MAX_DUTY;
        cfg_wr_data <= {3'b0, maxd};
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        ctl_fwd  = fwd;
        ctl_rev  = rev;
        ctl_duty = duty;
        ctl_max  = maxd;
        settings_loaded++;
    endtask

    // Mostly follows the rotor through the forward table; the rest is
    // enable/disable, unknown actions, random codes and invalid codes.
    // Unless allow_fault is set, invalid codes stop short of the fault.
    task automatic random_request(input bit allow_fault);
        int r;
        int c;
        int tgt;
        int last;
        logic [ACTION_W-1:0] act;
        logic [HALL_W-1:0] hall;
        r    = $urandom_range(0, 99);
        act  = ACT_HALL;
        hall = HALL_W'($urandom_range(0, 7));
        if (r < 6 || (!ctl_enabled && r < 20)) begin
            act = ACT_ENABLE;
        end else if (r < 10) begin
            act = ACT_DISABLE;
        end else if (r < 12) begin
            act = ACT_UNKNOWN;
        end else if (r < 20) begin
            if (allow_fault || ctl_errs < ERR_LIMIT)
                hall = $urandom_range(0, 1) ? 3'd7 : 3'd0;
            else
                hall = HALL_W'($urandom_range(1, 6));
        end else begin
            hall = HALL_W'($urandom_range(1, 6));
            if (r >= 32) begin
                last = ctl_sector;
                tgt  = spin_up ? (last + 1) % 6 : (last + 5) % 6;
                for (c = 1; c <= 6; c++)
                    if (((sector_entry(ctl_fwd, HALL_W'(c)) - 1) & 7) == tgt)
                        hall = HALL_W'(c);
            end
        end
        if ($urandom_range(0, 19) == 0)
            spin_up = !spin_up;
        send(act, hall, 1'b0, NONE);
    endtask

    // ------------------------------------------------------------------------
    // Report side: random stalls, with stall-free stretches
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = take_burst ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
            if ($urandom_range(0, 39) == 0)
                take_burst = !take_burst;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RESULT_W-1:0];
            if (status_queue.size() == 0) begin
                $error("report with no request waiting: %h", m_tdata);
                mismatch_count++;
            end else begin
                want = status_queue.pop_front();
                check_field("gate_en", want.gate_en, got.gate_en);
                check_field("pwm_a", want.pwm_a, got.pwm_a);
                check_field("pwm_b", want.pwm_b, got.pwm_b);
                check_field("pwm_c", want.pwm_c, got.pwm_c);
                check_field("position", want.position, got.position);
                check_field("hall_fault", want.hall_fault, got.hall_fault);
                check_field("running", want.running, got.running);
                check_field("padding", '0, m_tdata[87:RESULT_W]);
                reports_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int ph;
        int i;
        logic [TABLE_W-1:0] fwd;
        logic [TABLE_W-1:0] rev;
        logic [DUTY_W-1:0]  duty;
        logic [MAG_W-1:0]   maxd;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_FWD_TABLE;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= ACT_HALL;

        ctl_fwd     = FWD_TABLE_RST;
        ctl_rev     = REV_TABLE_RST;
        ctl_duty    = DRIVE_DUTY_RST;
        ctl_max     = MAX_DUTY_RST;
        ctl_enabled = 1'b0;
        ctl_fault   = 1'b0;
        ctl_sector  = '0;
        ctl_errs    = '0;
        ctl_hall    = '0;
        ctl_gates   = '0;
        ctl_pos     = '0;
        ctl_pwm     = '{default: '0};

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values, written back explicitly before the script
        load_setting(FWD_TABLE_RST, REV_TABLE_RST, DRIVE_DUTY_RST, MAX_DUTY_RST);
        for (i = 0; i < SCRIPT_LEN; i++)
            send(SCRIPT[i].act, SCRIPT[i].hall, SCRIPT[i].typed, SCRIPT[i].want);
        drain();

        // random phases, each under its own register setting
        for (ph = 0; ph < PHASES; ph++) begin
            fwd  = FWD_TABLE_RST;
            rev  = REV_TABLE_RST;
            duty = DRIVE_DUTY_RST;
            maxd = MAX_DUTY_RST;
            case (ph)
                0: duty = -16'sd2000;               // reverse table
                1: begin                            // clamp to zero
                    duty = 16'h7FFF;
                    maxd = '0;
                end
                2: duty = 16'h8000;                 // most negative duty
                3: begin                            // entries all 0: sector 7
                    fwd  = '0;
                    rev  = '1;
                    duty = '0;
                end
                4: begin                            // entries all 7
                    fwd  = '1;
                    rev  = '0;
                    duty = 16'hFFFF;
                    maxd = 15'd1;
                end
                5, 6: begin
                    fwd  = TABLE_W'($urandom_range(0, 262143));
                    rev  = TABLE_W'($urandom_range(0, 262143));
                    duty = DUTY_W'($urandom_range(0, 65535));
                    maxd = MAG_W'($urandom_range(0, 32767));
                end
                default: maxd = 15'd1000;           // clamp below the duty
            endcase
            load_setting(fwd, rev, duty, maxd);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                random_request(1'b0);
                // now and then let the pipeline run dry mid-phase
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
            drain();
        end

        // latch the Hall fault last: only reset would clear it
        load_setting(FWD_TABLE_RST, REV_TABLE_RST, DRIVE_DUTY_RST, MAX_DUTY_RST);
        send(ACT_ENABLE, 3'd1, 1'b0, NONE);
        send(ACT_HALL, 3'd5, 1'b0, NONE);   // valid code clears the count
        send(ACT_HALL, 3'd0, 1'b0, NONE);
        send(ACT_HALL, 3'd7, 1'b0, NONE);
        send(ACT_HALL, 3'd0, 1'b0, NONE);
        send(ACT_HALL, 3'd7, 1'b0, NONE);   // fourth in a row
        send(ACT_ENABLE, 3'd2, 1'b0, NONE); // refused
        for (i = 0; i < TAIL_ITEMS; i++)
            random_request(1'b1);
        drain();
        repeat (8) @(posedge aclk);

        $display("testbench: %0d requests, %0d reports checked, %0d register settings",
                 requests_sent, reports_checked, settings_loaded);
        $display("testbench: rotation both ways, invalid codes, duty sign and clamp "
                 , "extremes, fault latch");
        if (mismatch_count == 0 && status_queue.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
